[sv/adf_pkg.sv]
// Package for the ASCII line to DMX frame block: sizes, character codes, function
// codes, parse phases and the parser result bundle. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package adf_pkg;

    localparam int CHANNELS = 512;
    localparam int MAX_LINE = 2048;

    localparam int ADDR_W = $clog2(CHANNELS);
    localparam int CH_W   = $clog2(CHANNELS + 1);
    localparam int LEN_W  = $clog2(MAX_LINE + 1);
    localparam int ACC_W  = 9;
    localparam int MUL_W  = ACC_W + 4;

    localparam int VALUE_MAX = 255;
    localparam int ACC_SAT   = 256;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [4:0] {
        PH_EXPECT = 5'b00001,
        PH_SIGN   = 5'b00010,
        PH_DIGITS = 5'b00100,
        PH_AFTER  = 5'b01000,
        PH_STOP   = 5'b10000
    } adf_phase_t;

    typedef struct packed {
        logic              sh_we;
        logic [ADDR_W-1:0] sh_addr;
        logic [7:0]        sh_data;
        logic              updated;
        logic              dropped;
        logic [CH_W-1:0]   copy_end;
    } adf_parse_res_t;

endpackage

`default_nettype wire

[sv/adf_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module adf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/adf_parser.sv]
// Line parser: holds the per-line parse state and turns one byte plus the
// live value of the current channel into a shadow write and commit request.
// Depends on adf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adf_parser (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [7:0]             rx_byte,
    input  wire logic [7:0]             live_value,
    output logic [adf_pkg::ADDR_W-1:0]  look_addr,
    output adf_pkg::adf_parse_res_t     res
);

    adf_pkg::adf_phase_t             phase_reg, phase_next;
    logic [adf_pkg::ACC_W-1:0]       accum_reg, accum_next;
    logic                            neg_reg, neg_next;
    logic [adf_pkg::CH_W-1:0]        next_ch_reg, next_ch_next;
    logic [adf_pkg::LEN_W-1:0]       len_reg, len_next;
    logic                            ovf_reg, ovf_next;
    logic                            diff_reg, diff_next;

    logic                            is_digit, is_blank, is_sign;
    logic [adf_pkg::ACC_W-1:0]       digit_val;
    logic [adf_pkg::MUL_W-1:0]       acc_wide, acc_sum;
    logic [adf_pkg::ACC_W-1:0]       acc_sat;
    logic [7:0]                      fin_val;
    logic                            fin_in_range, fin_diff, fin_stop;
    logic [adf_pkg::CH_W-1:0]        nc_fin;
    logic                            run_after, run_begin, do_fin;

    assign is_digit  = (rx_byte >= adf_pkg::CHAR_ZERO) && (rx_byte <= adf_pkg::CHAR_NINE);
    assign is_blank  = (rx_byte == adf_pkg::CHAR_SPACE) || (rx_byte == adf_pkg::CHAR_TAB)
                    || (rx_byte == adf_pkg::CHAR_VT) || (rx_byte == adf_pkg::CHAR_FF);
    assign is_sign   = (rx_byte == adf_pkg::CHAR_PLUS) || (rx_byte == adf_pkg::CHAR_MINUS);
    assign digit_val = adf_pkg::ACC_W'(rx_byte[3:0]);

    // Times ten as two shifts and an add, then saturate just above the clamp.
    assign acc_wide = adf_pkg::MUL_W'(accum_reg);
    assign acc_sum  = (acc_wide << 3) + (acc_wide << 1) + adf_pkg::MUL_W'(digit_val);
    assign acc_sat  = (acc_sum > adf_pkg::MUL_W'(adf_pkg::ACC_SAT))
                    ? adf_pkg::ACC_W'(adf_pkg::ACC_SAT) : acc_sum[adf_pkg::ACC_W-1:0];

    assign fin_val = neg_reg ? 8'd0
                   : ((accum_reg > adf_pkg::ACC_W'(adf_pkg::VALUE_MAX))
                      ? 8'(adf_pkg::VALUE_MAX) : accum_reg[7:0]);
    assign fin_in_range = next_ch_reg < adf_pkg::CH_W'(adf_pkg::CHANNELS);
    assign fin_diff     = fin_in_range && (live_value != fin_val);
    assign nc_fin       = fin_in_range ? next_ch_reg + adf_pkg::CH_W'(1) : next_ch_reg;
    assign fin_stop     = nc_fin >= adf_pkg::CH_W'(adf_pkg::CHANNELS);

    assign look_addr = next_ch_reg[adf_pkg::ADDR_W-1:0];

    always_comb
    begin
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        neg_next     = neg_reg;
        next_ch_next = next_ch_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        diff_next    = diff_reg;
        run_after    = 1'b0;
        run_begin    = 1'b0;
        do_fin       = 1'b0;
        res.sh_we    = 1'b0;
        res.sh_addr  = next_ch_reg[adf_pkg::ADDR_W-1:0];
        res.sh_data  = fin_val;
        res.updated  = 1'b0;
        res.dropped  = 1'b0;
        res.copy_end = next_ch_reg;

        if (step && (rx_byte == adf_pkg::CHAR_LF))
        begin
            if (ovf_reg)
            begin
                res.dropped = 1'b1;
            end
            else
            begin
                do_fin       = (phase_reg == adf_pkg::PH_DIGITS);
                res.sh_we    = do_fin && fin_in_range;
                res.updated  = diff_reg || (do_fin && fin_diff);
                res.copy_end = do_fin ? nc_fin : next_ch_reg;
            end
            phase_next   = adf_pkg::PH_EXPECT;
            accum_next   = '0;
            neg_next     = 1'b0;
            next_ch_next = adf_pkg::CH_W'(1);
            len_next     = '0;
            ovf_next     = 1'b0;
            diff_next    = 1'b0;
        end
        else if (step && (rx_byte != adf_pkg::CHAR_CR) && !ovf_reg)
        begin
            if (len_reg < adf_pkg::LEN_W'(adf_pkg::MAX_LINE))
            begin
                len_next = len_reg + adf_pkg::LEN_W'(1);
                unique case (phase_reg)
                    adf_pkg::PH_EXPECT:
                    begin
                        if (is_digit || is_sign)
                        begin
                            run_begin = 1'b1;
                        end
                        else if (!is_blank)
                        begin
                            phase_next = adf_pkg::PH_STOP;
                        end
                    end
                    adf_pkg::PH_SIGN:
                    begin
                        if (is_digit)
                        begin
                            accum_next = digit_val;
                            phase_next = adf_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = adf_pkg::PH_STOP;
                        end
                    end
                    adf_pkg::PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            accum_next = acc_sat;
                        end
                        else
                        begin
                            // The number ends here; unless the channel limit stops
                            // the line, the same byte is handled like one after a number.
                            res.sh_we    = fin_in_range;
                            diff_next    = diff_reg || fin_diff;
                            next_ch_next = nc_fin;
                            if (fin_stop)
                            begin
                                phase_next = adf_pkg::PH_STOP;
                            end
                            else
                            begin
                                run_after = 1'b1;
                            end
                        end
                    end
                    adf_pkg::PH_AFTER:
                    begin
                        run_after = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                if (run_after)
                begin
                    if (is_blank)
                    begin
                        phase_next = adf_pkg::PH_AFTER;
                    end
                    else if (rx_byte == adf_pkg::CHAR_COMMA)
                    begin
                        phase_next = adf_pkg::PH_EXPECT;
                    end
                    else if (is_digit || is_sign)
                    begin
                        run_begin = 1'b1;
                    end
                    else
                    begin
                        phase_next = adf_pkg::PH_STOP;
                    end
                end

                if (run_begin)
                begin
                    neg_next   = (rx_byte == adf_pkg::CHAR_MINUS);
                    accum_next = is_digit ? digit_val : '0;
                    phase_next = is_digit ? adf_pkg::PH_DIGITS : adf_pkg::PH_SIGN;
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= adf_pkg::PH_EXPECT;
            accum_reg   <= '0;
            neg_reg     <= 1'b0;
            next_ch_reg <= adf_pkg::CH_W'(1);
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            diff_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            neg_reg     <= neg_next;
            next_ch_reg <= next_ch_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            diff_reg    <= diff_next;
        end
    end

endmodule

`default_nettype wire

[sv/ascii_line_to_dmx_frame.sv]
// Top level of the ASCII line to DMX frame block: stream ports, sequencer,
// commit copy engine and the live and shadow frame memories.
// Depends on adf_pkg, adf_ram and adf_parser.
//
// Usage: each input word is either a received serial character (s_tuser = 0)
// or a read of one live channel (s_tuser = 1). Lines of decimal numbers are
// parsed into a shadow frame; at LF the written channels are copied into the
// live frame if any of them changed and the line was not too long. Every
// input word gives exactly one output word with the flags frame_updated and
// line_dropped and, for a read, the live channel value.
//
// Timing: a word is accepted only while the sequencer is idle. A character
// or a read passes through accept, live memory lookup, parse and result
// hand-off before the next word can be accepted. An LF that commits adds the
// copy of its written channels, one channel per cycle through the shadow
// memory read port and the live memory write port. The result appears on
// m_tvalid in the cycle after the hand-off step.
//
// Reset clears the parse state and output valid; then the clearing pass writes
// zero to all 512 channels of the live frame while s_tready stays low.
// If the receiver stalls, the result stays in the output register and the
// next input word is still accepted and processed; its result waits in the
// sequencer until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module ascii_line_to_dmx_frame (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // rx_byte[7:0], read_channel[16:8], zero[23:17]
    input  wire logic        s_tuser,   // func[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // frame_updated[0], line_dropped[1],
                                        // read_value[9:2], zero[15:10]
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOOK  = 6'b000010,
        ST_PARSE = 6'b000100,
        ST_COPY  = 6'b001000,
        ST_DONE  = 6'b010000,
        ST_CLEAR = 6'b100000
    } adf_state_t;

    adf_state_t                  state_reg, state_next;

    // Captured input word.
    logic                        func_reg;
    logic [7:0]                  byte_reg;
    logic [8:0]                  rc_reg;

    // Result waiting for the output register.
    logic                        res_upd_reg;
    logic                        res_drop_reg;
    logic [7:0]                  res_val_reg;

    // Copy engine.
    logic [adf_pkg::CH_W-1:0]    copy_ch_reg, copy_ch_next;
    logic [adf_pkg::CH_W-1:0]    copy_end_reg;
    logic                        pend_reg;
    logic [adf_pkg::ADDR_W-1:0]  pend_addr_reg;
    logic                        rd_issue;

    // Clearing pass over the live frame after reset.
    logic [adf_pkg::ADDR_W-1:0]  clr_addr_reg;

    logic                        m_tvalid_reg;
    logic [15:0]                 m_tdata_reg;

    logic                        accept, out_free, parse_step;
    logic [adf_pkg::ADDR_W-1:0]  look_addr, live_raddr;
    logic [7:0]                  live_rdata, shadow_rdata;
    logic [7:0]                  read_value;
    logic                        live_we;
    logic [adf_pkg::ADDR_W-1:0]  live_waddr;
    logic [7:0]                  live_wdata;
    adf_pkg::adf_parse_res_t     pres;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign parse_step = (state_reg == ST_PARSE) && (func_reg == adf_pkg::FUNC_BYTE);
    assign rd_issue   = (state_reg == ST_COPY) && (copy_ch_reg < copy_end_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign live_raddr = (func_reg == adf_pkg::FUNC_READ) ? adf_pkg::ADDR_W'(rc_reg) : look_addr;
    assign read_value = (32'(rc_reg) < adf_pkg::CHANNELS) ? live_rdata : 8'd0;

    // The live write port serves the clearing pass after reset and the commit copy.
    assign live_we    = pend_reg || (state_reg == ST_CLEAR);
    assign live_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : pend_addr_reg;
    assign live_wdata = (state_reg == ST_CLEAR) ? 8'd0 : shadow_rdata;

    adf_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (parse_step),
        .rx_byte    (byte_reg),
        .live_value (live_rdata),
        .look_addr  (look_addr),
        .res        (pres)
    );

    // Live frame: read for lookups, written by the clearing pass and the commit copy.
    adf_ram #(
        .WIDTH (8),
        .DEPTH (adf_pkg::CHANNELS)
    ) u_live_ram (
        .clk   (clk),
        .we    (live_we),
        .waddr (live_waddr),
        .wdata (live_wdata),
        .raddr (live_raddr),
        .rdata (live_rdata)
    );

    // Shadow frame: written by the parser, read by the commit copy.
    adf_ram #(
        .WIDTH (8),
        .DEPTH (adf_pkg::CHANNELS)
    ) u_shadow_ram (
        .clk   (clk),
        .we    (pres.sh_we),
        .waddr (pres.sh_addr),
        .wdata (pres.sh_data),
        .raddr (copy_ch_reg[adf_pkg::ADDR_W-1:0]),
        .rdata (shadow_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        copy_ch_next = copy_ch_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == adf_pkg::ADDR_W'(adf_pkg::CHANNELS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_PARSE;
            end
            ST_PARSE:
            begin
                copy_ch_next = adf_pkg::CH_W'(1);
                state_next   = pres.updated ? ST_COPY : ST_DONE;
            end
            ST_COPY:
            begin
                if (rd_issue)
                begin
                    copy_ch_next = copy_ch_reg + adf_pkg::CH_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= rd_issue;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + adf_pkg::ADDR_W'(1);
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser;
            byte_reg <= s_tdata[7:0];
            rc_reg   <= s_tdata[16:8];
        end
        if (state_reg == ST_PARSE)
        begin
            res_upd_reg  <= (func_reg == adf_pkg::FUNC_BYTE) && pres.updated;
            res_drop_reg <= (func_reg == adf_pkg::FUNC_BYTE) && pres.dropped;
            res_val_reg  <= (func_reg == adf_pkg::FUNC_READ) ? read_value : 8'd0;
            copy_end_reg <= pres.copy_end;
        end
        copy_ch_reg   <= copy_ch_next;
        pend_addr_reg <= copy_ch_reg[adf_pkg::ADDR_W-1:0];
        if ((state_reg == ST_DONE) && out_free)
        begin
            m_tdata_reg <= {6'd0, res_val_reg, res_drop_reg, res_upd_reg};
        end
    end

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_live_write_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_COPY))
        else $error("live frame written outside the commit copy");

    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) |-> (copy_ch_reg <= copy_end_reg))
        else $error("commit copy ran past the last written channel");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(m_tdata_reg[0] && m_tdata_reg[1]))
        else $error("a line is both committed and dropped");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_free) |=> m_tvalid_reg && (state_reg == ST_IDLE))
        else $error("result not handed to the output register");
`endif

endmodule

`default_nettype wire

[sim/tb_ascii_line_to_dmx_frame.sv]
// Self-checking testbench for ascii_line_to_dmx_frame: sends serial characters and live
// channel reads, and checks every output word against a line parser kept in the bench.
// Depends on adf_pkg and the ascii_line_to_dmx_frame RTL.
`timescale 1ns / 1ps

module tb_ascii_line_to_dmx_frame;

    localparam int RANDOM_WORDS = 925;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = adf_pkg::CHANNELS + 100;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int REPORT_MAX   = 10;

    // One expected output word.
    typedef struct {
        logic       updated;
        logic       dropped;
        logic [7:0] value;
    } dmx_result_t;

    // Tracks the live and shadow frames and the line parser. note_word works out the
    // output word that each accepted input word must produce; check_word compares the
    // words that leave the block against them in order.
    class dmx_line_tracker;
        logic [7:0]          live   [adf_pkg::CHANNELS];
        logic [7:0]          shadow [adf_pkg::CHANNELS];
        adf_pkg::adf_phase_t phase;
        logic [8:0]          accum;
        logic                neg;
        logic [9:0]          next_ch;
        logic [11:0]         line_len;
        logic                overflow;
        logic                differs;
        dmx_result_t         pending[$];
        int                  errors;

        function new();
            int k;
            for (k = 0; k < adf_pkg::CHANNELS; k++)
            begin
                live[k]   = 8'd0;
                shadow[k] = 8'd0;
            end
            errors = 0;
            start_line();
        endfunction

        function void start_line();
            phase    = adf_pkg::PH_EXPECT;
            accum    = 9'd0;
            neg      = 1'b0;
            next_ch  = 10'd1;
            line_len = 12'd0;
            overflow = 1'b0;
            differs  = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == adf_pkg::CHAR_SPACE || c == adf_pkg::CHAR_TAB
                || c == adf_pkg::CHAR_VT || c == adf_pkg::CHAR_FF;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= adf_pkg::CHAR_ZERO && c <= adf_pkg::CHAR_NINE;
        endfunction

        function bit is_sign(logic [7:0] c);
            return c == adf_pkg::CHAR_PLUS || c == adf_pkg::CHAR_MINUS;
        endfunction

        function void begin_number(logic [7:0] c);
            neg   = 1'b0;
            accum = 9'd0;
            if (is_digit(c))
            begin
                accum = 9'(c - adf_pkg::CHAR_ZERO);
                phase = adf_pkg::PH_DIGITS;
            end
            else
            begin
                neg   = (c == adf_pkg::CHAR_MINUS);
                phase = adf_pkg::PH_SIGN;
            end
        endfunction

        // Writes the finished number to the next channel. Returns 0 once the channel
        // limit has stopped the line.
        function bit finish_number();
            logic [7:0] v;
            v = neg ? 8'd0
                    : ((accum > adf_pkg::VALUE_MAX) ? 8'(adf_pkg::VALUE_MAX) : accum[7:0]);
            if (next_ch < adf_pkg::CHANNELS)
            begin
                shadow[next_ch] = v;
                if (live[next_ch] != v)
                    differs = 1'b1;
                next_ch++;
            end
            if (next_ch >= adf_pkg::CHANNELS)
            begin
                phase = adf_pkg::PH_STOP;
                return 1'b0;
            end
            phase = adf_pkg::PH_AFTER;
            return 1'b1;
        endfunction

        // Handles a character that follows a complete number.
        function void after_number(logic [7:0] c);
            if (is_blank(c))
                return;
            if (c == adf_pkg::CHAR_COMMA)
                phase = adf_pkg::PH_EXPECT;
            else if (is_digit(c) || is_sign(c))
                begin_number(c);
            else
                phase = adf_pkg::PH_STOP;
        endfunction

        function void parse_char(logic [7:0] c);
            int unsigned t;
            case (phase)
                adf_pkg::PH_EXPECT:
                begin
                    if (is_blank(c))
                        return;
                    if (is_digit(c) || is_sign(c))
                        begin_number(c);
                    else
                        phase = adf_pkg::PH_STOP;
                end
                adf_pkg::PH_SIGN:
                begin
                    if (is_digit(c))
                    begin
                        accum = 9'(c - adf_pkg::CHAR_ZERO);
                        phase = adf_pkg::PH_DIGITS;
                    end
                    else
                        phase = adf_pkg::PH_STOP;
                end
                adf_pkg::PH_DIGITS:
                begin
                    if (is_digit(c))
                    begin
                        // The accumulator saturates just above the largest value.
                        t     = 32'(accum) * 10 + 32'(c - adf_pkg::CHAR_ZERO);
                        accum = (t > adf_pkg::ACC_SAT) ? 9'(adf_pkg::ACC_SAT) : t[8:0];
                        return;
                    end
                    // The terminating character is then treated like one after a number.
                    if (finish_number())
                        after_number(c);
                end
                adf_pkg::PH_AFTER:
                    after_number(c);
                default:
                begin
                end
            endcase
        endfunction

        function void note_word(logic func, logic [7:0] c, logic [8:0] ch);
            dmx_result_t r;
            int          k;
            r.updated = 1'b0;
            r.dropped = 1'b0;
            r.value   = 8'd0;
            if (func == adf_pkg::FUNC_READ)
                r.value = (ch < adf_pkg::CHANNELS) ? live[ch] : 8'd0;
            else if (c == adf_pkg::CHAR_CR)
            begin
                // Carriage returns are dropped everywhere.
            end
            else if (c == adf_pkg::CHAR_LF)
            begin
                if (overflow)
                    r.dropped = 1'b1;
                else
                begin
                    if (phase == adf_pkg::PH_DIGITS)
                        void'(finish_number());
                    if (differs)
                    begin
                        for (k = 1; k < next_ch && k < adf_pkg::CHANNELS; k++)
                            live[k] = shadow[k];
                        r.updated = 1'b1;
                    end
                end
                start_line();
            end
            else if (!overflow)
            begin
                if (line_len < adf_pkg::MAX_LINE)
                begin
                    line_len++;
                    parse_char(c);
                end
                else
                    overflow = 1'b1;
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_word(logic [15:0] d);
            dmx_result_t r;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: output word 0x%04h with nothing expected", $realtime, d);
                return;
            end
            r = pending.pop_front();
            if (d[0] !== r.updated || d[1] !== r.dropped || d[9:2] !== r.value)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: mismatch, expected updated=%0d dropped=%0d value=%0d, %s",
                             $realtime, r.updated, r.dropped, r.value,
                             $sformatf("got updated=%0d dropped=%0d value=%0d",
                                       d[0], d[1], d[9:2]));
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    dmx_line_tracker tracker;
    logic [7:0]      line_buf[$];
    logic [7:0]      prev_line[$];
    int              words_sent;
    int              cycle_count;
    bit              quiet;
    bit              hold_request;

    ascii_line_to_dmx_frame u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none once quiet.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                // Long stall so that the block fills up and pushes back on its input.
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Every output word that is taken is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_word(m_tdata);
    end

    // Offers one word, now and then with a random gap before it, and waits until the block takes it.
    // s_tvalid is left high afterwards so back-to-back words need no second assignment.
    task automatic send_word(logic func, logic [7:0] c, logic [8:0] ch);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'd0, ch, c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_word(func, c, ch);
        if (func == adf_pkg::FUNC_READ || c != adf_pkg::CHAR_CR)
            words_sent++;
    endtask

    // Reads a live channel; mostly the low channels that lines write, sometimes any.
    task automatic send_read();
        logic [8:0] ch;
        ch = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 14));
        send_word(adf_pkg::FUNC_READ, 8'($urandom), ch);
    endtask

    // Sends the buffered line, with reads slipped in between its characters.
    task automatic send_line();
        int k;
        for (k = 0; k < line_buf.size(); k++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_read();
            send_word(adf_pkg::FUNC_BYTE, line_buf[k], 9'($urandom));
        end
    endtask

    task automatic send_text(string s);
        int k;
        for (k = 0; k < s.len(); k++)
            send_word(adf_pkg::FUNC_BYTE, s[k], 9'($urandom));
    endtask

    // Appends one character to the line being built.
    function automatic void add_char(logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    function automatic void put_blanks(int unsigned min_count);
        int unsigned n;
        n = $urandom_range(min_count, 2);
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0:       add_char(adf_pkg::CHAR_TAB);
                1:       add_char(adf_pkg::CHAR_VT);
                2:       add_char(adf_pkg::CHAR_FF);
                default: add_char(adf_pkg::CHAR_SPACE);
            endcase
        end
    endfunction

    // Appends a decimal number: mostly small, some around the clamp point, some huge,
    // now and then with a sign or leading zeros.
    function automatic void put_number(bit force_sign);
        int unsigned v;
        int unsigned k;
        string       digits;
        if (force_sign || $urandom_range(0, 4) == 0)
            add_char($urandom_range(0, 1) ? adf_pkg::CHAR_MINUS : adf_pkg::CHAR_PLUS);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) add_char(adf_pkg::CHAR_ZERO);
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(250, 260);
            1:       v = $urandom_range(1000, 2000000000);
            default: v = $urandom_range(0, 120);
        endcase
        digits = $sformatf("%0d", v);
        for (k = 0; k < digits.len(); k++)
            add_char(digits[k]);
    endfunction

    // Appends a separator. Returns 1 when the separator is empty, so the next number
    // has to start with a sign.
    function automatic bit put_separator();
        int unsigned pick;
        pick = $urandom_range(0, 5);
        if (pick <= 2)
        begin
            put_blanks(1);
            return 1'b0;
        end
        if (pick <= 4)
        begin
            put_blanks(0);
            add_char(adf_pkg::CHAR_COMMA);
            put_blanks(0);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Builds a well-formed line with random content, now and then broken by junk,
    // and with carriage returns sprinkled in.
    function automatic void build_line();
        int unsigned count;
        int unsigned k;
        int unsigned pos;
        bit          force_sign;
        line_buf.delete();
        force_sign = 1'b0;
        count = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0)
            put_blanks(1);
        for (k = 0; k < count; k++)
        begin
            if (k > 0)
                force_sign = put_separator();
            put_number(force_sign);
        end
        if ($urandom_range(0, 1) == 0)
            put_blanks(0);
        if ($urandom_range(0, 3) == 0)
        begin
            pos = $urandom_range(0, line_buf.size());
            case ($urandom_range(0, 5))
                0: line_buf.insert(pos, 8'($urandom_range(8'h61, 8'h7A)));
                1: line_buf.insert(pos, 8'h00);
                2:
                begin
                    // A sign with no digits after it.
                    line_buf.insert(pos, adf_pkg::CHAR_SPACE);
                    line_buf.insert(pos, $urandom_range(0, 1) ? adf_pkg::CHAR_MINUS
                                                              : adf_pkg::CHAR_PLUS);
                end
                3:
                begin
                    line_buf.insert(pos, adf_pkg::CHAR_COMMA);
                    line_buf.insert(pos, adf_pkg::CHAR_COMMA);
                end
                default: line_buf.insert(pos, 8'($urandom));
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            line_buf.insert($urandom_range(0, line_buf.size()), adf_pkg::CHAR_CR);
        if ($urandom_range(0, 2) == 0)
            add_char(adf_pkg::CHAR_CR);
        add_char(adf_pkg::CHAR_LF);
    endfunction

    function automatic void build_noise();
        line_buf.delete();
        repeat ($urandom_range(1, 12)) add_char(8'($urandom));
        add_char(adf_pkg::CHAR_LF);
    endfunction

    initial
    begin
        int  random_start;
        bit  hold_fired;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = adf_pkg::FUNC_BYTE;
        s_tdata      = 24'd0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        hold_fired   = 1'b0;
        words_sent   = 0;
        tracker      = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: comma and blank separators, both signs, a negative value, the
        // clamp, a CR before LF, reads of written and unwritten channels including both
        // ends of the channel field, an empty line, and digits followed by junk.
        send_text("7,+255 -3 999\r\n");
        send_word(adf_pkg::FUNC_READ, 8'hFF, 9'd1);
        send_word(adf_pkg::FUNC_READ, 8'h00, 9'd2);
        send_word(adf_pkg::FUNC_READ, 8'hFF, 9'd4);
        send_word(adf_pkg::FUNC_READ, 8'h00, 9'd0);
        send_word(adf_pkg::FUNC_READ, 8'hFF, 9'd511);
        send_text("\n");
        send_text("1a\n");

        // Random part: mostly well-formed lines, some repeated unchanged, some noise.
        random_start = words_sent;
        while (words_sent < random_start + RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0:       build_noise();
                1:
                begin
                    if (prev_line.size() != 0)
                        line_buf = prev_line;
                    else
                        build_line();
                end
                default: build_line();
            endcase
            prev_line = line_buf;
            send_line();
            if (!hold_fired && words_sent >= random_start + 200)
            begin
                hold_fired   = 1'b1;
                hold_request = 1'b1;
            end
            if (words_sent >= random_start + RANDOM_WORDS * 85 / 100)
                quiet = 1'b1;
        end
        s_tvalid <= 1'b0;

        // Drain, then give a late or stray word time to show up.
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
